// ----- src/ctfp_pkg.sv -----
// Package for the circle tangent core: request and response types,
// pipeline record types and the fixed-point constants.
// No dependencies.
package ctfp_pkg;

   // Fraction bits of the rotation cosine and sine.
   localparam int TRIG_BITS = 30;
   // One root bit per square-root stage, one quotient bit per divider stage.
   localparam int SQ_STEPS = 35;
   localparam int DV_STEPS = 31;
   localparam int RAD_W = 2 * SQ_STEPS;
   localparam int SQ_REM_W = SQ_STEPS + 3;
   localparam int NUM_W = 66;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        radius;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               left_side;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      logic signed [31:0] tip_x;
      logic signed [31:0] tip_y;
   } rsp_type;

   // Fields that ride along with every request through the pipeline.
   typedef struct packed {
      logic               v;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [30:0]        r;
      logic               left;
      logic               outside;
   } side_type;

   // One square-root recurrence: partial remainder, root so far, radicand left.
   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_STEPS-1:0] root;
      logic [RAD_W-1:0]    rad;
   } sqs_type;

   // One restoring-division recurrence.
   typedef struct packed {
      logic [SQ_STEPS-1:0] rem;
      logic [DV_STEPS-1:0] q;
      logic [DV_STEPS-1:0] num;
   } dvs_type;

endpackage

// ----- src/circle_tangent_from_point_core.sv -----
// Tangent point from an external point to a circle, fully pipelined.
// Depends on ctfp_pkg.
//
// Throughput: one request per cycle while the output skid buffer is empty;
// the 35 square-root stages and the 31 divider stages each retire one bit
// per cycle in parallel.
// Reset clears all valid bits and the output skid buffer; no response is
// offered until a request has passed through.
module circle_tangent_from_point_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ctfp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ctfp_pkg::rsp_type rsp_data
);
   import ctfp_pkg::*;

   typedef struct packed {
      side_type           s;
      logic [65:0]        ax2;
      logic [65:0]        ay2;
      logic [61:0]        rr;
   } sqr_type;

   typedef struct packed {
      side_type s;
      sqs_type  dq;
      sqs_type  eq;
   } sqp_type;

   typedef struct packed {
      side_type            s;
      logic [SQ_STEPS-1:0] d;
      dvs_type             cq;
      dvs_type             sq;
   } dvp_type;

   typedef struct packed {
      side_type           s;
      logic signed [64:0] p_xc;
      logic signed [64:0] p_ys;
      logic signed [64:0] p_yc;
      logic signed [64:0] p_xs;
   } mul_type;

   typedef struct packed {
      side_type           s;
      logic signed [65:0] xx;
      logic signed [65:0] yy;
   } sum_type;

   typedef struct packed {
      side_type           s;
      logic signed [36:0] xx;
      logic signed [36:0] yy;
   } dsc_type;

   // One root bit: bring down two radicand bits and try root*4+1.
   function automatic sqs_type sq_step(sqs_type x);
      logic [SQ_REM_W+1:0] cur;
      logic [SQ_REM_W+1:0] trial;
      sqs_type             y;
      cur   = {x.rem, x.rad[RAD_W-1 -: 2]};
      trial = {3'b000, x.root, 2'b01};
      y.rad = {x.rad[RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
         y.rem  = SQ_REM_W'(cur - trial);
         y.root = {x.root[SQ_STEPS-2:0], 1'b1};
      end else begin
         y.rem  = cur[SQ_REM_W-1:0];
         y.root = {x.root[SQ_STEPS-2:0], 1'b0};
      end
      return y;
   endfunction

   // One quotient bit of a restoring division by d.
   function automatic dvs_type dv_step(dvs_type x, logic [SQ_STEPS-1:0] d);
      logic [SQ_STEPS:0] cur;
      dvs_type           y;
      cur   = {x.rem, x.num[DV_STEPS-1]};
      y.num = {x.num[DV_STEPS-2:0], 1'b0};
      if (cur >= {1'b0, d}) begin
         y.rem = SQ_STEPS'(cur - {1'b0, d});
         y.q   = {x.q[DV_STEPS-2:0], 1'b1};
      end else begin
         y.rem = cur[SQ_STEPS-1:0];
         y.q   = {x.q[DV_STEPS-2:0], 1'b0};
      end
      return y;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [37:0] v);
      if (v > 38'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -38'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   logic     skid_full_ff, skid_full_in;
   rsp_type  skid_ff, skid_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;
   logic     en;

   side_type a_ff, a_in;
   sqr_type  b_ff, b_in;
   sqp_type  c_ff, c_in;
   sqp_type  sq_ff [SQ_STEPS];
   sqp_type  sq_in [SQ_STEPS];
   dvp_type  p_ff, p_in;
   dvp_type  dv_ff [DV_STEPS];
   dvp_type  dv_in [DV_STEPS];
   mul_type  m_ff, m_in;
   sum_type  s_ff, s_in;
   dsc_type  ds_ff, ds_in;
   rsp_type  f_ff, f_in;
   logic     f_v_ff, f_v_in;

   // The whole pipeline moves unless the skid buffer holds a response.
   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // Stage A: differences from the point to the center.
   always_comb begin
      a_in.v       = req_valid;
      a_in.dx      = 33'(req_data.center_x) - 33'(req_data.point_x);
      a_in.dy      = 33'(req_data.center_y) - 33'(req_data.point_y);
      a_in.px      = req_data.point_x;
      a_in.py      = req_data.point_y;
      a_in.r       = req_data.radius;
      a_in.left    = req_data.left_side;
      a_in.outside = 1'b0;
   end

   // Stage B: squares of the distance components and of the radius.
   always_comb begin
      logic [32:0] ax;
      logic [32:0] ay;
      ax       = a_ff.dx[32] ? 33'(-a_ff.dx) : 33'(a_ff.dx);
      ay       = a_ff.dy[32] ? 33'(-a_ff.dy) : 33'(a_ff.dy);
      b_in.s   = a_ff;
      b_in.ax2 = 66'(ax * ax);
      b_in.ay2 = 66'(ay * ay);
      b_in.rr  = 62'(a_ff.r * a_ff.r);
   end

   // Stage C: squared distance, its excess over r squared, and the inside test.
   always_comb begin
      logic [65:0] dd;
      dd             = b_ff.ax2 + b_ff.ay2;
      c_in.s         = b_ff.s;
      c_in.s.outside = dd > 66'(b_ff.rr);
      c_in.dq.rem    = '0;
      c_in.dq.root   = '0;
      c_in.dq.rad    = RAD_W'(dd);
      c_in.eq.rem    = '0;
      c_in.eq.root   = '0;
      c_in.eq.rad    = RAD_W'(dd - 66'(b_ff.rr));
   end

   // Square-root stages for d and t, one root bit each.
   always_comb begin
      for (int i = 0; i < SQ_STEPS; i++) begin
         if (i == 0) begin
            sq_in[i].s  = c_ff.s;
            sq_in[i].dq = sq_step(c_ff.dq);
            sq_in[i].eq = sq_step(c_ff.eq);
         end else begin
            sq_in[i].s  = sq_ff[i-1].s;
            sq_in[i].dq = sq_step(sq_ff[i-1].dq);
            sq_in[i].eq = sq_step(sq_ff[i-1].eq);
         end
      end
   end

   // Divider setup: dividends t*2^30 + d/2 and r*2^30 + d/2.
   always_comb begin
      logic [SQ_STEPS-1:0] d;
      logic [NUM_W-1:0]    nc;
      logic [NUM_W-1:0]    ns;
      d = sq_ff[SQ_STEPS-1].dq.root;
      nc = {1'b0, sq_ff[SQ_STEPS-1].eq.root, {TRIG_BITS{1'b0}}} + NUM_W'(d >> 1);
      ns = {5'b00000, sq_ff[SQ_STEPS-1].s.r, {TRIG_BITS{1'b0}}} + NUM_W'(d >> 1);
      p_in.s      = sq_ff[SQ_STEPS-1].s;
      p_in.d      = d;
      p_in.cq.rem = nc[NUM_W-1:DV_STEPS];
      p_in.cq.num = nc[DV_STEPS-1:0];
      p_in.cq.q   = '0;
      p_in.sq.rem = ns[NUM_W-1:DV_STEPS];
      p_in.sq.num = ns[DV_STEPS-1:0];
      p_in.sq.q   = '0;
   end

   // Divider stages for cosine and sine, one quotient bit each.
   always_comb begin
      for (int i = 0; i < DV_STEPS; i++) begin
         if (i == 0) begin
            dv_in[i].s  = p_ff.s;
            dv_in[i].d  = p_ff.d;
            dv_in[i].cq = dv_step(p_ff.cq, p_ff.d);
            dv_in[i].sq = dv_step(p_ff.sq, p_ff.d);
         end else begin
            dv_in[i].s  = dv_ff[i-1].s;
            dv_in[i].d  = dv_ff[i-1].d;
            dv_in[i].cq = dv_step(dv_ff[i-1].cq, dv_ff[i-1].d);
            dv_in[i].sq = dv_step(dv_ff[i-1].sq, dv_ff[i-1].d);
         end
      end
   end

   // Rotation products; the side flag sets the sign of the sine.
   always_comb begin
      logic signed [31:0] cs;
      logic signed [31:0] sn;
      cs = $signed({1'b0, dv_ff[DV_STEPS-1].cq.q});
      sn = $signed({1'b0, dv_ff[DV_STEPS-1].sq.q});
      if (!dv_ff[DV_STEPS-1].s.left) begin
         sn = -sn;
      end
      m_in.s    = dv_ff[DV_STEPS-1].s;
      m_in.p_xc = 65'(dv_ff[DV_STEPS-1].s.dx * cs);
      m_in.p_ys = 65'(dv_ff[DV_STEPS-1].s.dy * sn);
      m_in.p_yc = 65'(dv_ff[DV_STEPS-1].s.dy * cs);
      m_in.p_xs = 65'(dv_ff[DV_STEPS-1].s.dx * sn);
   end

   // Rotated vector before scaling.
   always_comb begin
      s_in.s  = m_ff.s;
      s_in.xx = 66'(m_ff.p_xc) - 66'(m_ff.p_ys);
      s_in.yy = 66'(m_ff.p_yc) + 66'(m_ff.p_xs);
   end

   // Scale by 2^-30, round half away from zero.
   always_comb begin
      logic [65:0] mx;
      logic [65:0] my;
      logic [35:0] qx;
      logic [35:0] qy;
      mx = s_ff.xx[65] ? 66'(-s_ff.xx) : 66'(s_ff.xx);
      my = s_ff.yy[65] ? 66'(-s_ff.yy) : 66'(s_ff.yy);
      qx = 36'((mx + 66'(1 << (TRIG_BITS - 1))) >> TRIG_BITS);
      qy = 36'((my + 66'(1 << (TRIG_BITS - 1))) >> TRIG_BITS);
      ds_in.s  = s_ff.s;
      ds_in.xx = s_ff.xx[65] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      ds_in.yy = s_ff.yy[65] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
   end

   // Add to the point, saturate, and zero the result for an inside point.
   always_comb begin
      f_v_in = ds_ff.s.v;
      f_in.valid_res = ds_ff.s.outside;
      if (ds_ff.s.outside) begin
         f_in.tip_x = sat32(38'(ds_ff.s.px) + 38'(ds_ff.xx));
         f_in.tip_y = sat32(38'(ds_ff.s.py) + 38'(ds_ff.yy));
      end else begin
         f_in.tip_x = '0;
         f_in.tip_y = '0;
      end
   end

   // Pipeline registers; only valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.v  <= 1'b0;
         b_ff.s.v <= 1'b0;
         c_ff.s.v <= 1'b0;
         for (int i = 0; i < SQ_STEPS; i++) begin
            sq_ff[i].s.v <= 1'b0;
         end
         p_ff.s.v <= 1'b0;
         for (int i = 0; i < DV_STEPS; i++) begin
            dv_ff[i].s.v <= 1'b0;
         end
         m_ff.s.v  <= 1'b0;
         s_ff.s.v  <= 1'b0;
         ds_ff.s.v <= 1'b0;
         f_v_ff    <= 1'b0;
      end else if (en) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         c_ff  <= c_in;
         for (int i = 0; i < SQ_STEPS; i++) begin
            sq_ff[i] <= sq_in[i];
         end
         p_ff  <= p_in;
         for (int i = 0; i < DV_STEPS; i++) begin
            dv_ff[i] <= dv_in[i];
         end
         m_ff  <= m_in;
         s_ff  <= s_in;
         ds_ff <= ds_in;
         f_ff  <= f_in;
         f_v_ff <= f_v_in;
      end
   end

   // Output register with a skid buffer so request stall is registered.
   always_comb begin
      logic inject;
      inject       = f_v_ff && en;
      skid_full_in = skid_full_ff;
      skid_in      = skid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = skid_full_ff || inject;
         rsp_in       = skid_full_ff ? skid_ff : f_ff;
         skid_full_in = 1'b0;
      end else if (inject) begin
         skid_in      = f_ff;
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      skid_ff <= skid_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/ctfp_chk.sv -----
// Port-level checker for the circle tangent core, bound to its top level.
// Depends on ctfp_pkg and circle_tangent_from_point_core.
module ctfp_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ctfp_pkg::rsp_type rsp_data
);
   import ctfp_pkg::*;

   // A stalled response stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A point on or inside the circle gives a zero tip.
   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.tip_x == 0 && rsp_data.tip_y == 0)
      else $error("invalid response with nonzero tip");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // Requests are held off only after a stalled response.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without output backpressure");

endmodule

bind circle_tangent_from_point_core ctfp_chk u_ctfp_chk (.*);

// ----- verif/circle_tangent_checker.sv -----
`timescale 1ns / 100ps
// Checker for the circle tangent core: watches both channels, computes the
// expected tangent point of every accepted request and compares responses.
// Depends on ctfp_pkg.
module circle_tangent_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ctfp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ctfp_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import ctfp_pkg::*;

   rsp_type tip_queue[$];

   // Integer square root, floor, of a value below 2^70.
   function automatic logic [34:0] floor_root(logic [69:0] v);
      logic [34:0] acc;
      logic [34:0] trial;
      acc = '0;
      for (int b = 34; b >= 0; b--) begin
         trial = acc | (35'd1 << b);
         if ({35'd0, trial} * {35'd0, trial} <= v) acc = trial;
      end
      return acc;
   endfunction

   // Scale by 2^-30 with rounding to nearest, ties away from zero.
   function automatic logic signed [63:0] unscale(logic signed [63:0] v);
      logic [63:0] mag;
      mag = v < 0 ? -v : v;
      mag = (mag + (64'd1 << (TRIG_BITS - 1))) >> TRIG_BITS;
      return v < 0 ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // Expected response for one request.
   function automatic rsp_type tangent_tip(req_type q);
      rsp_type res;
      logic signed [63:0] dx, dy, px, py, cs, sn, xx, yy;
      logic [69:0] dist_sq, rad_sq;
      logic [63:0] d, t, r;
      px = 64'(q.point_x);
      py = 64'(q.point_y);
      dx = 64'(q.center_x) - px;
      dy = 64'(q.center_y) - py;
      r = {33'd0, q.radius};
      dist_sq = 70'(dx * dx) + 70'(dy * dy);
      rad_sq = 70'(r) * 70'(r);
      res = '0;
      if (dist_sq <= rad_sq) return res;
      d = 64'(floor_root(dist_sq));
      t = 64'(floor_root(dist_sq - rad_sq));
      cs = ((t << TRIG_BITS) + d / 2) / d;
      sn = ((r << TRIG_BITS) + d / 2) / d;
      if (!q.left_side) sn = -sn;
      xx = unscale(dx * cs - dy * sn);
      yy = unscale(dy * cs + dx * sn);
      res.valid_res = 1'b1;
      res.tip_x = clamp32(px + xx);
      res.tip_y = clamp32(py + yy);
      return res;
   endfunction

   // Record requests and compare responses at each edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) tip_queue.push_back(tangent_tip(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (tip_queue.size() == 0) begin
               $error("response with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = tip_queue.pop_front();
               if (want != rsp_data) fail_count <= fail_count + 1;
               if (want.valid_res != rsp_data.valid_res)
                  $error("valid_res: expected %0d, got %0d", want.valid_res,
                     rsp_data.valid_res);
               if (want.tip_x != rsp_data.tip_x)
                  $error("tip_x: expected %0d, got %0d", want.tip_x, rsp_data.tip_x);
               if (want.tip_y != rsp_data.tip_y)
                  $error("tip_y: expected %0d, got %0d", want.tip_y, rsp_data.tip_y);
            end
         end
         pending_count <= tip_queue.size();
      end
   end
endmodule

// ----- verif/tb_circle_tangent_from_point_core.sv -----
`timescale 1ns / 100ps
// Testbench top for the circle tangent core: drives directed and random
// requests with random gaps and stalls; checking is in circle_tangent_checker.
module tb_circle_tangent_from_point_core;
   import ctfp_pkg::*;

   localparam int LATENCY = 74;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   int      rsp_wait = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   circle_tangent_from_point_core uut (.*);

   circle_tangent_checker checker_i (.*);

   // Stop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // After each taken response, wait a random number of cycles, with calm stretches.
   always @(posedge clock) begin
      int w;
      if (rsp_valid && !rsp_stall) begin
         w = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 12);
         rsp_wait  <= w;
         rsp_stall <= (w != 0);
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait  <= 0;
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'h7fffffff - $urandom_range(0, 3);
         2: return 32'h80000000 + $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 32'h0fffff)) - 32'sh80000;
      endcase
   endfunction

   // Hand over one request after a random gap, holding it until accepted.
   task automatic send_request(req_type q);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_case(int cx, int cy, int r, int px, int py, bit left);
      req_type q;
      q.center_x = cx;
      q.center_y = cy;
      q.radius = 31'(r);
      q.point_x = px;
      q.point_y = py;
      q.left_side = left;
      send_request(q);
   endtask

   initial begin
      req_type q;
      logic [31:0] cx, cy;
      logic [31:0] ang;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: inside, on, at the center, zero radius, extremes, saturation.
      send_case(0, 0, 32'h10000, 0, 0, 1'b1);
      send_case(0, 0, 32'h50000, 32'h30000, 32'h40000, 1'b1);
      send_case(0, 0, 32'h10000, 32'h8000, 0, 1'b0);
      send_case(0, 0, 32'h10000, 32'h50000, 0, 1'b1);
      send_case(0, 0, 32'h10000, 32'h50000, 0, 1'b0);
      send_case(32'h100000, -32'h100000, 0, 0, 0, 1'b1);
      send_case(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b1);
      send_case(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
      send_case(32'h7fffffff, 32'h80000000, 1, 32'h80000000, 32'h7fffffff, 1'b1);
      send_case(32'h80000000, 0, 32'h40000000, 32'h7fffffff, 0, 1'b1);
      send_case(0, 32'h7fffffff, 32'h7ffffffe, 0, 32'h80000000, 1'b0);
      send_case(5, 5, 32'h7fffffff, 5, 5, 1'b1);
      send_case(1, 0, 0, 0, 0, 1'b0);
      send_case(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1);
      send_case(-32'h20000, 32'h30000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);

      // Hold off until the pipeline drains.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // Random: mostly points outside the circle, some inside or on it.
      for (int n = 0; n < 1850; n++) begin
         q.center_x = any_coord();
         q.center_y = any_coord();
         q.point_x = any_coord();
         q.point_y = any_coord();
         q.left_side = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: q.radius = 31'($urandom);
            1: q.radius = 31'($urandom_range(0, 3));
            2: begin
               q.point_x = q.center_x + $signed($urandom_range(0, 65535)) - 32768;
               q.point_y = q.center_y + $signed($urandom_range(0, 65535)) - 32768;
               q.radius = 31'($urandom_range(0, 50000));
            end
            default: begin
               ang = $urandom_range(1, 30);
               q.radius = 31'($urandom >> (ang + 1));
               cx = q.center_x;
               cy = q.center_y;
               q.point_x = cx + ($urandom >> ang) - (32'h1 << (31 - ang));
               q.point_y = cy + ($urandom >> ang) - (32'h1 << (31 - ang));
            end
         endcase
         send_request(q);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
